// ===== rtl/tbga_pkg.sv =====
// Shared types, constants and the code-to-glyph mapping for the glyph address block.
package tbga_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [15:0] code_t;
  typedef logic [12:0] glyph_t;

  typedef enum logic [1:0] {
    CFG_GLYPH_WIDTH    = 2'd0,
    CFG_GLYPH_HEIGHT   = 2'd1,
    CFG_BITS_PER_PIXEL = 2'd2,
    CFG_GLYPH_BASE     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
  } text_item_t;

  typedef struct packed {
    cfg_idx_e    index;
    logic [23:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic [15:0] char_code;
    glyph_t      glyph_index;
    logic [25:0] glyph_offset;
    logic        substituted;
  } glyph_item_t;

  typedef struct packed {
    logic [6:0]  glyph_width;
    logic [6:0]  glyph_height;
    logic [3:0]  bits_per_pixel;
    logic [23:0] glyph_base;
  } cfg_t;

  typedef struct packed {
    logic   subst;
    glyph_t glyph;
  } map_t;

  localparam logic [6:0]  RST_GLYPH_WIDTH    = 7'd8;
  localparam logic [6:0]  RST_GLYPH_HEIGHT   = 7'd8;
  localparam logic [3:0]  RST_BITS_PER_PIXEL = 4'd1;
  localparam logic [23:0] RST_GLYPH_BASE     = 24'd0;

  localparam code_t SINGLE_BIAS  = 16'h01E0;
  localparam code_t SYM_BASE     = 16'h8140;
  localparam code_t KANA_LO      = 16'h8240;
  localparam code_t KANA_HI      = 16'h84BF;
  localparam code_t KANJI1_FIRST = 16'h8840;
  localparam code_t KANJI2_FIRST = 16'h9890;
  localparam code_t KANJI3_FIRST = 16'hE040;
  localparam code_t ALIAS_A      = 16'hF056;
  localparam code_t ALIAS_B      = 16'hF040;
  localparam code_t MISSING_CODE = 16'h81A1;
  localparam code_t ROW_GLYPHS   = 16'd192;

  localparam glyph_t MISSING_GLYPH = glyph_t'(MISSING_CODE - SYM_BASE);
  localparam glyph_t ALIAS_A_GLYPH = glyph_t'(16'h81FA - SYM_BASE);
  localparam glyph_t ALIAS_B_GLYPH = glyph_t'(16'h81F9 - SYM_BASE);

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= 8'h80 && b <= 8'h9F) || b >= 8'hE0;
  endfunction

  function automatic logic in_span(input code_t c, input code_t lo, input code_t hi);
    return c >= lo && c <= hi;
  endfunction

  function automatic map_t map_code(input code_t c);
    logic [7:0] hi;
    logic [7:0] lo;
    code_t      g;
    logic       unsup;
    map_t       m;
    hi    = c[15:8];
    lo    = c[7:0];
    g     = '0;
    unsup = 1'b0;
    if (hi == 8'h00) begin
      g = c + SINGLE_BIAS;
    end else if (in_span(c, SYM_BASE, 16'h81FF)) begin
      g = c - SYM_BASE;
    end else if (in_span(c, 16'h839F, 16'h83D6)) begin
      g = c - 16'h81C0;
    end else if (in_span(c, 16'h8440, 16'h8491)) begin
      g = c - 16'h8200;
    end else if (in_span(c, 16'h8740, 16'h879C)) begin
      g = c - 16'h82C0;
    end else if (in_span(c, KANA_LO, KANA_HI)) begin
      // hiragana and katakana blocks; other codes in this span map to glyph zero
      if (in_span(c, 16'h8240, 16'h829A) || in_span(c, 16'h829F, 16'h82F1)) begin
        g = c - 16'h8180;
      end else if (in_span(c, 16'h8340, 16'h83FF)) begin
        g = c - 16'h81C0;
      end else begin
        g = '0;
      end
    end else if (in_span(c, KANJI1_FIRST, 16'h988F)) begin
      g = code_t'(hi - 8'h88) * ROW_GLYPHS + code_t'(lo) + 16'h0500;
    end else if (in_span(c, KANJI2_FIRST, 16'h9FFF)) begin
      g = code_t'(hi - 8'h98) * ROW_GLYPHS + code_t'(lo) + 16'h1100;
    end else if (in_span(c, KANJI3_FIRST, 16'hEAAF)) begin
      g = code_t'(hi - 8'hE0) * ROW_GLYPHS + code_t'(lo) + 16'h1700;
    end else begin
      unsup = 1'b1;
    end

    if (c == ALIAS_A) begin
      m.glyph = ALIAS_A_GLYPH;
      m.subst = 1'b0;
    end else if (c == ALIAS_B) begin
      m.glyph = ALIAS_B_GLYPH;
      m.subst = 1'b0;
    end else if (unsup) begin
      m.glyph = MISSING_GLYPH;
      m.subst = 1'b1;
    end else begin
      m.glyph = g[12:0];
      m.subst = 1'b0;
    end
    return m;
  endfunction

endpackage

// ===== rtl/tbga_stream_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
interface tbga_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/text_byte_to_glyph_address.sv =====
// Top level: text byte stream to glyph index and bitmap offset.
//
// text_i carries one raw byte per item. A lead byte (0x80-0x9F, 0xE0-0xFF) is
// held and the next byte completes a two-byte code; any other byte is a code
// by itself. Each completed code leaves one item on glyph_o with the code, the
// glyph index, the bitmap byte offset base + index * row_bytes * height, and
// a flag set when the missing-glyph box replaced an unsupported code. A lead
// byte gives no item.
// Throughput is one byte per cycle while glyph_o does not stall. A completing
// byte passes the code queue, lookup stage, multiply stage and output register.
// A two-entry code queue sits between the byte assembler and the lookup, so
// text_i drops ready only once the queue and all three stages are full while
// glyph_o stalls. cfg_i is always ready; the stride follows a write through the
// config register, pix_bits_q and stride_q. Reset clears the held lead, the
// queue and the stages and loads width 8, height 8, depth 1, base 0.
module text_byte_to_glyph_address import tbga_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbga_stream_if.sink   text_i,
  tbga_stream_if.sink   cfg_i,
  tbga_stream_if.source glyph_o
);

  cfg_t  cfg_q;
  logic  push_valid, push_ready;
  code_t push_code;
  logic  pop_valid, pop_ready;
  code_t pop_code;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width    <= RST_GLYPH_WIDTH;
      cfg_q.glyph_height   <= RST_GLYPH_HEIGHT;
      cfg_q.bits_per_pixel <= RST_BITS_PER_PIXEL;
      cfg_q.glyph_base     <= RST_GLYPH_BASE;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_GLYPH_WIDTH:    cfg_q.glyph_width    <= cfg_i.data.wdata[6:0];
        CFG_GLYPH_HEIGHT:   cfg_q.glyph_height   <= cfg_i.data.wdata[6:0];
        CFG_BITS_PER_PIXEL: cfg_q.bits_per_pixel <= cfg_i.data.wdata[3:0];
        CFG_GLYPH_BASE:     cfg_q.glyph_base     <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  tbga_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_code_o  (push_code)
  );

  tbga_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_code_i  (push_code),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_code_o   (pop_code)
  );

  tbga_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_code_i  (pop_code),
    .glyph_o     (glyph_o)
  );

endmodule

// ===== rtl/tbga_front.sv =====
// Front end: assembles one- and two-byte character codes from the text stream.
module tbga_front import tbga_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbga_stream_if.sink   text_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output code_t         push_code_o
);

  logic       lead_pending_q, lead_pending_d;
  logic [7:0] held_lead_q, held_lead_d;
  logic [7:0] text_byte;
  logic       byte_is_lead;
  logic       accept;

  assign text_byte    = text_i.data.text_byte;
  assign byte_is_lead = is_lead(text_byte);
  assign text_i.ready = push_ready_i;
  assign accept       = text_i.valid && text_i.ready;

  // a held lead takes any byte as its trail, even another lead byte
  assign push_valid_o = text_i.valid && (lead_pending_q || !byte_is_lead);
  assign push_code_o  = lead_pending_q ? {held_lead_q, text_byte} : {8'h00, text_byte};

  always_comb begin
    lead_pending_d = lead_pending_q;
    held_lead_d    = held_lead_q;
    if (accept) begin
      if (lead_pending_q) begin
        lead_pending_d = 1'b0;
        held_lead_d    = 8'h00;
      end else if (byte_is_lead) begin
        lead_pending_d = 1'b1;
        held_lead_d    = text_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
      held_lead_q    <= 8'h00;
    end else begin
      lead_pending_q <= lead_pending_d;
      held_lead_q    <= held_lead_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !lead_pending_q && byte_is_lead)
      |=> (lead_pending_q && held_lead_q == $past(text_byte)))
    else $error("lead byte not held");

endmodule

// ===== rtl/tbga_queue.sv =====
// Small FIFO of assembled codes between front end and back end.
module tbga_queue import tbga_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  code_t push_code_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output code_t pop_code_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  code_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_code_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_code_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count lost an item");

endmodule

// ===== rtl/tbga_back.sv =====
// Back end: glyph lookup, per-glyph stride, offset multiply and output register.
module tbga_back import tbga_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  code_t         pop_code_i,
  tbga_stream_if.source glyph_o
);

  // stride pipeline: pix_bits_q and stride_q follow the config registers
  logic [10:0] pix_bits_q;
  logic [10:0] row_round;
  logic [14:0] stride_q;

  // stage A: mapped code
  logic   a_valid_q;
  code_t  a_code_q;
  map_t   a_map_q;
  // stage B: product
  logic        b_valid_q;
  code_t       b_code_q;
  map_t        b_map_q;
  logic [27:0] b_prod_q;
  // stage C: output
  logic        c_valid_q;
  glyph_item_t c_item_q;

  logic a_ready, b_ready, c_ready;

  assign c_ready     = !c_valid_q || glyph_o.ready;
  assign b_ready     = !b_valid_q || c_ready;
  assign a_ready     = !a_valid_q || b_ready;
  assign pop_ready_o = a_ready;

  assign row_round = pix_bits_q + 11'd7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_bits_q <= 11'(RST_GLYPH_WIDTH) * 11'(RST_BITS_PER_PIXEL);
      stride_q   <= 15'(RST_GLYPH_HEIGHT);
    end else begin
      pix_bits_q <= 11'(cfg_i.glyph_width) * 11'(cfg_i.bits_per_pixel);
      stride_q   <= 15'(row_round[10:3]) * 15'(cfg_i.glyph_height);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= pop_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && pop_valid_i) begin
      a_code_q <= pop_code_i;
      a_map_q  <= map_code(pop_code_i);
    end
    if (b_ready && a_valid_q) begin
      b_code_q <= a_code_q;
      b_map_q  <= a_map_q;
      b_prod_q <= 28'(a_map_q.glyph) * 28'(stride_q);
    end
    if (c_ready && b_valid_q) begin
      c_item_q.char_code    <= b_code_q;
      c_item_q.glyph_index  <= b_map_q.glyph;
      c_item_q.glyph_offset <= b_prod_q[25:0] + 26'(cfg_i.glyph_base);
      c_item_q.substituted  <= b_map_q.subst;
    end
  end

  assign glyph_o.valid = c_valid_q;
  assign glyph_o.data  = c_item_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (glyph_o.valid && glyph_o.data.substituted)
      |-> (glyph_o.data.glyph_index == MISSING_GLYPH))
    else $error("substituted item without the missing-glyph box");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_ready) |=> (a_valid_q && $stable(a_code_q)))
    else $error("mapped code dropped while stalled");

endmodule
